### design/eqbs_pkg.sv
// Shared constants, operation codes and controller/datapath link types.
package eqbs_pkg;

    localparam int BOARD   = 8;
    localparam int ROW_W   = $clog2(BOARD);
    localparam int PTR_W   = ROW_W + 1;
    localparam int DIAG_N  = 2 * BOARD - 1;
    localparam int FUNC_W  = 2;

    typedef logic [ROW_W-1:0]  t_coord;
    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [BOARD-1:0]  t_cols;
    typedef logic [DIAG_N-1:0] t_diag;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_PLACE = 2'd1,
        FUNC_FIRST = 2'd2,
        FUNC_NEXT  = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_PLACE,
        OP_FRESH,
        OP_RESUME,
        OP_ADVANCE,
        OP_TAKE,
        OP_NEXT_COL,
        OP_BACK_SKIP,
        OP_BACK_LIFT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   load;
        logic   found;
    } t_dp_cmd;

    typedef struct packed {
        logic row_end;
        logic row_fixed;
        logic col_end;
        logic cell_free;
        logic row_zero;
        logic prev_fixed;
    } t_dp_stat;

endpackage

### design/eqbs_req_if.sv
// Request channel: operation code and fixed-queen coordinates.
interface eqbs_req_if;
    import eqbs_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [ROW_W-1:0]    row_index;
    logic [ROW_W-1:0]    col_index;

    modport source (output valid, func, row_index, col_index, input ready);
    modport sink   (input valid, func, row_index, col_index, output ready);
endinterface

### design/eqbs_rsp_if.sv
// Response channel: found flag and one queen column per row.
interface eqbs_rsp_if;
    import eqbs_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [ROW_W-1:0] queen_row0;
    logic [ROW_W-1:0] queen_row1;
    logic [ROW_W-1:0] queen_row2;
    logic [ROW_W-1:0] queen_row3;
    logic [ROW_W-1:0] queen_row4;
    logic [ROW_W-1:0] queen_row5;
    logic [ROW_W-1:0] queen_row6;
    logic [ROW_W-1:0] queen_row7;

    modport source (output valid, found, queen_row0, queen_row1, queen_row2, queen_row3,
                    queen_row4, queen_row5, queen_row6, queen_row7, input ready);
    modport sink   (input valid, found, queen_row0, queen_row1, queen_row2, queen_row3,
                    queen_row4, queen_row5, queen_row6, queen_row7, output ready);
endinterface

### design/eqbs_datapath.sv
// Board datapath: fixed and search marks, queen columns, search pointers, result register.
module eqbs_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  eqbs_pkg::t_dp_cmd   i_cmd,
    input  eqbs_pkg::t_coord    i_row,
    input  eqbs_pkg::t_coord    i_col,
    output eqbs_pkg::t_dp_stat  o_stat,
    output logic                o_found,
    output eqbs_pkg::t_coord    o_queen [eqbs_pkg::BOARD]
);
    import eqbs_pkg::*;

    function automatic t_cols col_bit(t_coord c);
        return t_cols'(1) << c;
    endfunction

    function automatic t_diag rise_bit(t_coord r, t_coord c);
        return t_diag'(1) << (PTR_W'(r) + PTR_W'(c));
    endfunction

    function automatic t_diag fall_bit(t_coord r, t_coord c);
        return t_diag'(1) << (PTR_W'(r) + PTR_W'(BOARD - 1) - PTR_W'(c));
    endfunction

    t_cols  r_fixed;
    t_coord r_queen [BOARD];
    t_cols  r_fix_col;
    t_diag  r_fix_rise;
    t_diag  r_fix_fall;
    t_cols  r_srch_col;
    t_diag  r_srch_rise;
    t_diag  r_srch_fall;
    t_ptr   r_row;
    t_ptr   r_cand;
    logic   r_found;
    t_coord r_res [BOARD];

    t_coord row3;
    t_coord cand3;
    t_ptr   prev_row;
    t_coord prev3;
    t_coord lift_col;

    assign row3     = r_row[ROW_W-1:0];
    assign cand3    = r_cand[ROW_W-1:0];
    assign prev_row = r_row - PTR_W'(1);
    assign prev3    = prev_row[ROW_W-1:0];
    assign lift_col = r_queen[prev3];

    always_comb begin
        o_stat.row_end    = r_row[ROW_W];
        o_stat.col_end    = r_cand[ROW_W];
        o_stat.row_fixed  = r_fixed[row3];
        o_stat.row_zero   = (r_row == '0);
        o_stat.prev_fixed = r_fixed[prev3];
        o_stat.cell_free  = ~|((r_fix_col | r_srch_col) & col_bit(cand3))
                          & ~|((r_fix_rise | r_srch_rise) & rise_bit(row3, cand3))
                          & ~|((r_fix_fall | r_srch_fall) & fall_bit(row3, cand3));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed     <= '0;
            r_fix_col   <= '0;
            r_fix_rise  <= '0;
            r_fix_fall  <= '0;
            r_srch_col  <= '0;
            r_srch_rise <= '0;
            r_srch_fall <= '0;
            r_row       <= '0;
            r_cand      <= '0;
            for (int k = 0; k < BOARD; k++) r_queen[k] <= '0;
        end else begin
            case (i_cmd.op)
                OP_CLEAR: begin
                    r_fixed     <= '0;
                    r_fix_col   <= '0;
                    r_fix_rise  <= '0;
                    r_fix_fall  <= '0;
                    r_srch_col  <= '0;
                    r_srch_rise <= '0;
                    r_srch_fall <= '0;
                    r_row       <= '0;
                    r_cand      <= '0;
                    for (int k = 0; k < BOARD; k++) r_queen[k] <= '0;
                end
                OP_PLACE: begin
                    // drop any search queens, then add the fixed one
                    r_srch_col  <= '0;
                    r_srch_rise <= '0;
                    r_srch_fall <= '0;
                    for (int k = 0; k < BOARD; k++) begin
                        if (k == int'(i_row)) r_queen[k] <= i_col;
                        else if (!r_fixed[k]) r_queen[k] <= '0;
                    end
                    r_fixed[i_row] <= 1'b1;
                    r_fix_col      <= r_fix_col | col_bit(i_col);
                    r_fix_rise     <= r_fix_rise | rise_bit(i_row, i_col);
                    r_fix_fall     <= r_fix_fall | fall_bit(i_row, i_col);
                    r_row          <= '0;
                end
                OP_FRESH: begin
                    r_srch_col  <= '0;
                    r_srch_rise <= '0;
                    r_srch_fall <= '0;
                    for (int k = 0; k < BOARD; k++)
                        if (!r_fixed[k]) r_queen[k] <= '0;
                    r_row  <= '0;
                    r_cand <= '0;
                end
                OP_RESUME: begin
                    r_row <= PTR_W'(BOARD);
                end
                OP_ADVANCE: begin
                    r_row  <= r_row + PTR_W'(1);
                    r_cand <= '0;
                end
                OP_TAKE: begin
                    r_queen[row3] <= cand3;
                    r_srch_col    <= r_srch_col | col_bit(cand3);
                    r_srch_rise   <= r_srch_rise | rise_bit(row3, cand3);
                    r_srch_fall   <= r_srch_fall | fall_bit(row3, cand3);
                    r_row         <= r_row + PTR_W'(1);
                    r_cand        <= '0;
                end
                OP_NEXT_COL: begin
                    r_cand <= r_cand + PTR_W'(1);
                end
                OP_BACK_SKIP: begin
                    r_row <= prev_row;
                end
                OP_BACK_LIFT: begin
                    // lift the previous queen and resume one column to its right
                    r_queen[prev3] <= '0;
                    r_srch_col     <= r_srch_col & ~col_bit(lift_col);
                    r_srch_rise    <= r_srch_rise & ~rise_bit(prev3, lift_col);
                    r_srch_fall    <= r_srch_fall & ~fall_bit(prev3, lift_col);
                    r_row          <= prev_row;
                    r_cand         <= PTR_W'(lift_col) + PTR_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // result register, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_found <= i_cmd.found;
            for (int k = 0; k < BOARD; k++)
                r_res[k] <= i_cmd.found ? r_queen[k] : '0;
        end
    end

    assign o_found = r_found;
    assign o_queen = r_res;

endmodule

### design/eqbs_ctrl.sv
// Search controller: request decode, backtracking sequence, response handshake.
module eqbs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  eqbs_pkg::t_func     i_func,
    output logic                o_req_ready,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    input  eqbs_pkg::t_dp_stat  i_stat,
    output eqbs_pkg::t_dp_cmd   o_cmd
);
    import eqbs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_BACK,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HELD,
        ST_DONE
    } t_status;

    t_state  r_state,  n_state;
    t_status r_status, n_status;
    logic    r_found,  n_found;
    logic    r_rsp_valid, n_rsp_valid;
    logic    accept;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign accept      = i_req_valid && o_req_ready;

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_found     = r_found;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        o_cmd.op    = OP_NONE;
        o_cmd.load  = 1'b0;
        o_cmd.found = r_found;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_func)
                        FUNC_CLEAR: begin
                            o_cmd.op = OP_CLEAR;
                            n_status = ST_IDLE;
                        end
                        FUNC_PLACE: begin
                            o_cmd.op = OP_PLACE;
                            n_status = ST_IDLE;
                        end
                        FUNC_NEXT: begin
                            if (r_status == ST_DONE) begin
                                n_found = 1'b0;
                                n_state = S_FINISH;
                            end else if (r_status == ST_HELD) begin
                                o_cmd.op = OP_RESUME;
                                n_state  = S_BACK;
                            end else begin
                                o_cmd.op = OP_FRESH;
                                n_state  = S_SEARCH;
                            end
                        end
                        default: begin
                            o_cmd.op = OP_FRESH;
                            n_state  = S_SEARCH;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (i_stat.row_end) begin
                    n_found  = 1'b1;
                    n_status = ST_HELD;
                    n_state  = S_FINISH;
                end else if (i_stat.row_fixed) begin
                    o_cmd.op = OP_ADVANCE;
                end else if (i_stat.col_end) begin
                    n_state = S_BACK;
                end else if (i_stat.cell_free) begin
                    o_cmd.op = OP_TAKE;
                end else begin
                    o_cmd.op = OP_NEXT_COL;
                end
            end
            S_BACK: begin
                if (i_stat.row_zero) begin
                    n_found  = 1'b0;
                    n_status = ST_DONE;
                    n_state  = S_FINISH;
                end else if (i_stat.prev_fixed) begin
                    o_cmd.op = OP_BACK_SKIP;
                end else begin
                    o_cmd.op = OP_BACK_LIFT;
                    n_state  = S_SEARCH;
                end
            end
            S_FINISH: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    o_cmd.load  = 1'b1;
                    n_rsp_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= ST_IDLE;
            r_found     <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_found     <= n_found;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule

### design/eight_queens_backtrack_solver_core.sv
// Top level of the 8-queens backtracking solver: controller, datapath and channel wiring.
//
//   channel  dir  handshake       beat contents
//   i_req    in   valid / ready   func, row_index, col_index
//   o_rsp    out  valid / ready   found, queen_row0 .. queen_row7
//
// Clear and place are executed on acceptance and give no beat. First/next walk the board
// one candidate column per cycle in the datapath, with backtrack steps in between, and
// then hand over the result. Next after exhaustion answers without a search. Requests are
// taken only when no search runs; a finished result waits in the output register, so a
// stalled o_rsp holds the next result's hand-over but not a following clear or place.
// Reset (synchronous, active low) empties the board and the search.
module eight_queens_backtrack_solver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    eqbs_req_if.sink    i_req,
    eqbs_rsp_if.source  o_rsp
);
    import eqbs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_coord   queen [BOARD];
    logic     found;

    // sequencing: decode the beat, drive one datapath step per cycle
    eqbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_func      (t_func'(i_req.func)),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // board state, conflict test and result register
    eqbs_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_row   (i_req.row_index),
        .i_col   (i_req.col_index),
        .o_stat  (stat),
        .o_found (found),
        .o_queen (queen)
    );

    assign o_rsp.found      = found;
    assign o_rsp.queen_row0 = queen[0];
    assign o_rsp.queen_row1 = queen[1];
    assign o_rsp.queen_row2 = queen[2];
    assign o_rsp.queen_row3 = queen[3];
    assign o_rsp.queen_row4 = queen[4];
    assign o_rsp.queen_row5 = queen[5];
    assign o_rsp.queen_row6 = queen[6];
    assign o_rsp.queen_row7 = queen[7];

endmodule

### tb/eight_queens_backtrack_solver_core_tb.sv
// Self-checking testbench for the 8-queens solver: directed and random requests, checked beat by beat.
`timescale 1ns / 1ps

module eight_queens_backtrack_solver_core_tb;
    import eqbs_pkg::*;

    localparam int DIRECTED_MAX = 30;
    localparam int RANDOM_ITEMS = 550;
    localparam int PHASE_BEATS  = 40;      // request beats per idling phase
    localparam int QUIET_LIMIT  = 100000;  // cycles without any beat before giving up
    localparam int DRAIN_CYCLES = 200;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        t_func  func;
        t_coord row;
        t_coord col;
    } t_request;

    typedef struct packed {
        logic               found;
        t_coord [BOARD-1:0] cols;
    } t_solution;

    typedef enum logic [1:0] {
        SEARCH_IDLE,
        SEARCH_HELD,
        SEARCH_DONE
    } t_search;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    logic i_clk;
    logic i_rst_n;

    eqbs_req_if req_bus ();
    eqbs_rsp_if rsp_bus ();

    eight_queens_backtrack_solver_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // board state as the solver should hold it
    logic [BOARD-1:0]   fixed_rows;
    t_coord [BOARD-1:0] placed_col;
    t_cols              col_busy;
    t_diag              rise_busy;
    t_diag              fall_busy;
    t_search            search_st;

    t_request  request_q[$];
    t_solution solution_q[$];

    t_request  next_req;
    t_request  seen_req;
    t_solution want;
    t_solution got;
    logic      req_taken;
    logic      rsp_taken;
    int        total_reqs;
    int        accepted_reqs;
    int        sent_count;
    int        quiet_cycles;
    int        mismatches;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- prediction

    function automatic void wipe_board();
        fixed_rows = '0;
        placed_col = '0;
        col_busy   = '0;
        rise_busy  = '0;
        fall_busy  = '0;
        search_st  = SEARCH_IDLE;
    endfunction

    function automatic void mark_cell(int r, int c, bit on);
        col_busy[c]             = on;
        rise_busy[r + c]        = on;
        fall_busy[r + BOARD-1-c] = on;
    endfunction

    function automatic bit cell_open(int r, int c);
        return !col_busy[c] && !rise_busy[r + c] && !fall_busy[r + BOARD-1-c];
    endfunction

    // Lift the queens that the search put down; fixed rows stay.
    function automatic void drop_search();
        if (search_st == SEARCH_HELD) begin
            for (int r = 0; r < BOARD; r++) begin
                if (!fixed_rows[r]) begin
                    mark_cell(r, int'(placed_col[r]), 1'b0);
                    placed_col[r] = '0;
                end
            end
        end
        search_st = SEARCH_IDLE;
    endfunction

    // Depth-first walk, rows ascending, columns ascending; resume backs out of
    // the last row of the held solution first.
    function automatic bit walk_board(bit resume);
        int r;
        int c;
        int start;
        bit back;
        r     = resume ? BOARD : 0;
        start = 0;
        back  = resume;
        forever begin
            if (back) begin
                r--;
                while (r >= 0 && fixed_rows[r]) r--;
                if (r < 0) begin
                    search_st = SEARCH_DONE;
                    return 1'b0;
                end
                start = int'(placed_col[r]) + 1;
                mark_cell(r, int'(placed_col[r]), 1'b0);
                placed_col[r] = '0;
                back = 1'b0;
            end
            if (r >= BOARD) begin
                search_st = SEARCH_HELD;
                return 1'b1;
            end
            if (fixed_rows[r]) begin
                r++;
                start = 0;
            end else begin
                back = 1'b1;
                for (c = start; c < BOARD && back; c++) begin
                    if (cell_open(r, c)) begin
                        placed_col[r] = t_coord'(c);
                        mark_cell(r, c, 1'b1);
                        back = 1'b0;
                    end
                end
                if (!back) begin
                    r++;
                    start = 0;
                end
            end
        end
    endfunction

    // Advance the board by one request; returns 1 when a response beat is due.
    function automatic bit apply_request(t_request rq, output t_solution sol);
        bit ok;
        sol = '0;
        case (rq.func)
            FUNC_CLEAR: begin
                wipe_board();
                return 1'b0;
            end
            FUNC_PLACE: begin
                drop_search();
                fixed_rows[rq.row] = 1'b1;
                placed_col[rq.row] = rq.col;
                mark_cell(int'(rq.row), int'(rq.col), 1'b1);
                return 1'b0;
            end
            default: begin
                if (rq.func == FUNC_NEXT && search_st == SEARCH_DONE) begin
                    ok = 1'b0;
                end else if (rq.func == FUNC_NEXT && search_st == SEARCH_HELD) begin
                    ok = walk_board(1'b1);
                end else begin
                    drop_search();
                    ok = walk_board(1'b0);
                end
                sol.found = ok;
                for (int r = 0; r < BOARD; r++) sol.cols[r] = ok ? placed_col[r] : '0;
                return 1'b1;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void add_request(t_func f, int row, int col);
        t_request rq;
        rq.func = f;
        rq.row  = t_coord'(row);
        rq.col  = t_coord'(col);
        request_q.push_back(rq);
    endfunction

    // searching requests carry random, ignored coordinates
    function automatic void add_search(t_func f);
        add_request(f, $urandom_range(0, BOARD-1), $urandom_range(0, BOARD-1));
    endfunction

    function automatic bit hold_off(bit sender);
        t_idle_mode mode;
        int         pct;
        mode = t_idle_mode'((sent_count / PHASE_BEATS) % 4);
        pct  = $urandom_range(0, 99);
        case (mode)
            IDLE_SEND: return sender && pct < 81;
            IDLE_RECV: return !sender && pct < 81;
            IDLE_BOTH: return pct < 31;
            default:   return 1'b0;
        endcase
    endfunction

    // ---------------------------------------------------------------- driver

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!req_bus.valid || req_taken) begin
                if (request_q.size() != 0 && !hold_off(1'b1)) begin
                    next_req          = request_q.pop_front();
                    req_bus.func      = next_req.func;
                    req_bus.row_index = next_req.row;
                    req_bus.col_index = next_req.col;
                    req_bus.valid     = 1'b1;
                    sent_count++;
                end else begin
                    req_bus.valid = 1'b0;
                end
            end
            rsp_bus.ready = !hold_off(1'b0);
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic report_field(string name, int exp_val, int act_val);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name,
                     exp_val, act_val);
    endtask

    always @(posedge i_clk) begin
        req_taken = req_bus.valid && req_bus.ready;
        rsp_taken = rsp_bus.valid && rsp_bus.ready;
        if (req_taken) begin
            seen_req.func = t_func'(req_bus.func);
            seen_req.row  = req_bus.row_index;
            seen_req.col  = req_bus.col_index;
            accepted_reqs++;
            if (apply_request(seen_req, want)) solution_q.push_back(want);
        end
        if (rsp_taken) begin
            got.found   = rsp_bus.found;
            got.cols[0] = rsp_bus.queen_row0;
            got.cols[1] = rsp_bus.queen_row1;
            got.cols[2] = rsp_bus.queen_row2;
            got.cols[3] = rsp_bus.queen_row3;
            got.cols[4] = rsp_bus.queen_row4;
            got.cols[5] = rsp_bus.queen_row5;
            got.cols[6] = rsp_bus.queen_row6;
            got.cols[7] = rsp_bus.queen_row7;
            if (solution_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: response beat with none expected, found %0d",
                             $realtime, got.found);
            end else begin
                want = solution_q.pop_front();
                if (got.found !== want.found)
                    report_field("found", want.found, got.found);
                for (int r = 0; r < BOARD; r++) begin
                    if (got.cols[r] !== want.cols[r])
                        report_field($sformatf("queen_row%0d", r), want.cols[r], got.cols[r]);
                end
            end
        end
        quiet_cycles = (req_taken || rsp_taken) ? 0 : quiet_cycles + 1;
    end

    // watchdog: a hung search or a lost beat stops every handshake
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(negedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        int full_board[BOARD];
        int places;
        int nexts;
        int noise;

        full_board        = '{0, 4, 7, 5, 2, 6, 1, 3};
        i_rst_n           = 1'b0;
        req_bus.valid     = 1'b0;
        req_bus.func      = FUNC_CLEAR;
        req_bus.row_index = '0;
        req_bus.col_index = '0;
        rsp_bus.ready     = 1'b0;
        req_taken         = 1'b0;
        rsp_taken         = 1'b0;
        accepted_reqs     = 0;
        sent_count        = 0;
        quiet_cycles      = 0;
        mismatches        = 0;
        wipe_board();

        // directed: next from idle, fresh first over a held solution,
        // abandoning by place, replacing a fixed row, conflicting fixed queens,
        // next after exhaustion, clear mid-search, fully fixed board
        add_search(FUNC_NEXT);
        add_search(FUNC_NEXT);
        add_search(FUNC_FIRST);
        add_request(FUNC_PLACE, 0, 0);
        add_search(FUNC_FIRST);
        add_request(FUNC_PLACE, 0, 7);
        add_search(FUNC_FIRST);
        add_search(FUNC_NEXT);
        add_request(FUNC_PLACE, 7, 0);
        add_search(FUNC_FIRST);
        add_search(FUNC_NEXT);
        add_search(FUNC_NEXT);
        add_search(FUNC_CLEAR);
        add_search(FUNC_FIRST);
        add_search(FUNC_CLEAR);
        add_search(FUNC_NEXT);
        add_search(FUNC_CLEAR);
        for (int r = 0; r < BOARD; r++) add_request(FUNC_PLACE, r, full_board[r]);
        add_search(FUNC_FIRST);
        add_search(FUNC_NEXT);
        add_search(FUNC_NEXT);
        add_search(FUNC_CLEAR);

        // random: mostly clear / place / first / next runs, some loose noise
        while (request_q.size() < DIRECTED_MAX + RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
                if ($urandom_range(0, 4) != 0) add_search(FUNC_CLEAR);
                places = $urandom_range(0, 4);
                repeat (places)
                    add_request(FUNC_PLACE, $urandom_range(0, BOARD-1),
                                $urandom_range(0, BOARD-1));
                add_search(($urandom_range(0, 4) == 0) ? FUNC_NEXT : FUNC_FIRST);
                nexts = $urandom_range(0, 10);
                repeat (nexts) add_search(FUNC_NEXT);
                if ($urandom_range(0, 5) == 0) begin
                    add_request(FUNC_PLACE, $urandom_range(0, BOARD-1),
                                $urandom_range(0, BOARD-1));
                    add_search(FUNC_NEXT);
                end
            end else begin
                noise = $urandom_range(1, 4);
                repeat (noise)
                    add_request(t_func'($urandom_range(0, 3)), $urandom_range(0, BOARD-1),
                                $urandom_range(0, BOARD-1));
            end
        end
        total_reqs = request_q.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_reqs < total_reqs) @(negedge i_clk);
        while (solution_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && solution_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
